// File: rtl/core/aesctr_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 CTR package
// Shared types, the S-box table and the round functions of the cipher.
// ----------------------------------------------------------------------------
package aesctr_pkg;

  localparam int BLK_W   = 128;
  localparam int CNT_W   = 5;
  localparam int DATA_W  = 64;
  localparam int IDX_W   = 2;
  localparam int TDATA_W = 136;
  localparam int ROUNDS  = 10;

  localparam logic [IDX_W-1:0] REG_KEY_UPPER = 2'd0;
  localparam logic [IDX_W-1:0] REG_KEY_LOWER = 2'd1;
  localparam logic [IDX_W-1:0] REG_IV_UPPER  = 2'd2;
  localparam logic [IDX_W-1:0] REG_IV_LOWER  = 2'd3;

  localparam logic [CNT_W-1:0] FULL_CNT = 5'd16;

  typedef struct packed {
    logic [BLK_W-1:0] ctr;
    logic [BLK_W-1:0] data;
    logic [CNT_W-1:0] cnt;
  } item_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } qstat_t;

  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

  localparam logic [79:0] RCON_TBL = 80'h01020408102040801b36;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    sbox = SBOX_TBL[2047 - 8*int'(x) -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [BLK_W-1:0] enc_round(input logic [BLK_W-1:0] s,
                                                 input logic [BLK_W-1:0] rk,
                                                 input logic last);
    logic [7:0] sb [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [BLK_W-1:0] o;
    for (int i = 0; i < 16; i++) sb[i] = sbox(s[127-8*i -: 8]);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[r+4*c] = sb[r + 4*((c+r) & 3)];
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (last) begin
        o[127-32*c -: 32] = {a0, a1, a2, a3};
      end else begin
        o[127-32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                             a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                             a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                             xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
      end
    end
    enc_round = o ^ rk;
  endfunction

  function automatic logic [BLK_W-1:0] next_key(input logic [BLK_W-1:0] rk,
                                                input int rnd);
    logic [31:0] w3, tmp, n0, n1, n2, n3;
    w3  = rk[31:0];
    tmp = {sbox(w3[23:16]) ^ RCON_TBL[79-8*(rnd-1) -: 8], sbox(w3[15:8]),
           sbox(w3[7:0]), sbox(w3[31:24])};
    n0 = rk[127:96] ^ tmp;
    n1 = rk[95:64] ^ n0;
    n2 = rk[63:32] ^ n1;
    n3 = rk[31:0] ^ n2;
    next_key = {n0, n1, n2, n3};
  endfunction

  function automatic logic [BLK_W-1:0] byte_mask(input logic [CNT_W-1:0] cnt);
    logic [BLK_W-1:0] m;
    for (int i = 0; i < 16; i++) m[127-8*i -: 8] = (CNT_W'(i) < cnt) ? 8'hff : 8'h00;
    byte_mask = m;
  endfunction

endpackage

// File: rtl/core/aesctr_front.sv
// ----------------------------------------------------------------------------
// AES-128 CTR front end
// Holds key and IV, advances the counter and queues one entry per block.
// ----------------------------------------------------------------------------
module aesctr_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wen,
  input  logic [aesctr_pkg::IDX_W-1:0]        cfg_index,
  input  logic [aesctr_pkg::DATA_W-1:0]       cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [aesctr_pkg::TDATA_W-1:0]      in_tdata,
  input  logic                                in_tuser,
  input  aesctr_pkg::qstat_t                  q_stat,
  output logic                                q_push,
  output aesctr_pkg::item_t                   q_item,
  output logic [aesctr_pkg::BLK_W-1:0]        key
);
  import aesctr_pkg::*;

  logic [BLK_W-1:0]  key_r, key_nxt;
  logic [BLK_W-1:0]  iv_r, iv_nxt;
  logic [63:0]       head_r, head_nxt;
  logic [31:0]       mid_r, mid_nxt;
  logic [31:0]       word_r, word_nxt;
  logic [31:0]       base_word;
  logic [CNT_W-1:0]  cnt;
  logic              acc;

  assign in_tready = q_stat.ready;
  assign acc       = in_tvalid && in_tready;
  assign key       = key_r;

  always_comb begin
    key_nxt = key_r;
    iv_nxt  = iv_r;
    if (cfg_wen) begin
      unique case (cfg_index)
        REG_KEY_UPPER: key_nxt[127:64] = cfg_wdata;
        REG_KEY_LOWER: key_nxt[63:0]   = cfg_wdata;
        REG_IV_UPPER:  iv_nxt[127:64]  = cfg_wdata;
        REG_IV_LOWER:  iv_nxt[63:0]    = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    head_nxt  = in_tuser ? iv_r[127:64] : head_r;
    mid_nxt   = in_tuser ? iv_r[63:32] : mid_r;
    base_word = in_tuser ? {iv_r[7:0], iv_r[15:8], iv_r[23:16], iv_r[31:24]} : word_r;
    word_nxt  = base_word + 32'd1;
    cnt       = (in_tdata[132:128] > FULL_CNT) ? FULL_CNT : in_tdata[132:128];
  end

  assign q_push      = acc;
  assign q_item.ctr  = {head_nxt, mid_nxt, word_nxt[7:0], word_nxt[15:8],
                        word_nxt[23:16], word_nxt[31:24]};
  assign q_item.data = {in_tdata[63:0], in_tdata[127:64]};
  assign q_item.cnt  = cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r  <= '0;
      iv_r   <= '0;
      head_r <= '0;
      mid_r  <= '0;
      word_r <= '0;
    end else begin
      key_r <= key_nxt;
      iv_r  <= iv_nxt;
      if (acc) begin
        head_r <= head_nxt;
        mid_r  <= mid_nxt;
        word_r <= word_nxt;
      end
    end
  end

endmodule

// File: rtl/core/aesctr_fifo.sv
// ----------------------------------------------------------------------------
// AES-128 CTR queue
// Two-entry queue between the counter front end and the round pipeline.
// ----------------------------------------------------------------------------
module aesctr_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  aesctr_pkg::item_t  wr_item,
  input  logic               pop,
  output aesctr_pkg::item_t  rd_item,
  output aesctr_pkg::qstat_t stat
);
  import aesctr_pkg::*;

  item_t      mem [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign stat.valid = (cnt_r != 2'd0);
  assign stat.ready = (cnt_r != 2'd2);
  assign do_push    = push && stat.ready;
  assign do_pop     = pop && stat.valid;
  assign rd_item    = mem[rd_r];
  assign cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= ~wr_r;
      if (do_pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/aesctr_back.sv
// ----------------------------------------------------------------------------
// AES-128 CTR round pipeline
// One stage per round with the key schedule alongside, then the output XOR.
// ----------------------------------------------------------------------------
module aesctr_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  aesctr_pkg::qstat_t                 q_stat,
  input  aesctr_pkg::item_t                  q_item,
  output logic                               q_pop,
  input  logic [aesctr_pkg::BLK_W-1:0]       key,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [aesctr_pkg::TDATA_W-1:0]     out_tdata
);
  import aesctr_pkg::*;

  logic [BLK_W-1:0] st_r  [ROUNDS+1];
  logic [BLK_W-1:0] rk_r  [ROUNDS+1];
  logic [BLK_W-1:0] dat_r [ROUNDS+1];
  logic [CNT_W-1:0] cnt_r [ROUNDS+1];
  logic [ROUNDS:0]  vld_r;
  logic [BLK_W-1:0] res_r;
  logic [CNT_W-1:0] rcnt_r;
  logic             ovld_r;
  logic             en;

  assign en    = !ovld_r || out_tready;
  assign q_pop = en;

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]  <= q_item.ctr ^ key;
      rk_r[0]  <= key;
      dat_r[0] <= q_item.data;
      cnt_r[0] <= q_item.cnt;
      for (int k = 1; k <= ROUNDS; k++) begin
        rk_r[k]  <= next_key(rk_r[k-1], k);
        st_r[k]  <= enc_round(st_r[k-1], next_key(rk_r[k-1], k), k == ROUNDS);
        dat_r[k] <= dat_r[k-1];
        cnt_r[k] <= cnt_r[k-1];
      end
      res_r  <= (dat_r[ROUNDS] ^ st_r[ROUNDS]) & byte_mask(cnt_r[ROUNDS]);
      rcnt_r <= cnt_r[ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ovld_r <= 1'b0;
    end else if (en) begin
      vld_r  <= {vld_r[ROUNDS-1:0], q_stat.valid};
      ovld_r <= vld_r[ROUNDS];
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {3'b000, rcnt_r, res_r[63:0], res_r[127:64]};

endmodule

// File: rtl/core/aes128_ctr_stream_cipher.sv
// ----------------------------------------------------------------------------
// AES-128 CTR stream cipher
// Encrypts or decrypts a stream of 16-byte blocks in counter mode.
// ----------------------------------------------------------------------------
// The input stream carries one block per transaction: tdata holds the data
// words and the count of valid bytes, tuser marks the first block of a
// message, which reloads the counter from the IV. Key and IV are written
// through the configuration port while the block is idle; the user keeps to
// this, the block does not enforce it. Each block passes through the queue,
// an initial key stage, ten round stages and the output register. The block
// takes one transaction per cycle while the receiver does not stall; the
// ten-stage round pipeline, with the key schedule running beside it, sets
// that figure. When the receiver stalls the whole pipeline holds, the
// two-entry queue fills and the input then stalls. Reset clears the key,
// the IV, the counter and all valid flags; no clearing pass follows.
// ----------------------------------------------------------------------------
module aes128_ctr_stream_cipher (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wen,
  input  logic [aesctr_pkg::IDX_W-1:0]    cfg_index,
  input  logic [aesctr_pkg::DATA_W-1:0]   cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // data_upper, data_lower, valid_bytes, zero fill
  input  logic [aesctr_pkg::TDATA_W-1:0]  in_tdata,
  // message_start
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // result_upper, result_lower, result_bytes, zero fill
  output logic [aesctr_pkg::TDATA_W-1:0]  out_tdata
);
  import aesctr_pkg::*;

  qstat_t           q_stat;
  item_t            wr_item, rd_item;
  logic             q_push, q_pop;
  logic [BLK_W-1:0] key;

  aesctr_front u_front (
    .clk, .rst_n, .cfg_wen, .cfg_index, .cfg_wdata,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_stat, .q_push, .q_item(wr_item), .key
  );

  aesctr_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .wr_item, .pop(q_pop), .rd_item, .stat(q_stat)
  );

  aesctr_back u_back (
    .clk, .rst_n, .q_stat, .q_item(rd_item), .q_pop, .key,
    .out_tvalid, .out_tready, .out_tdata
  );

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[132:128] <= FULL_CNT)
    else $error("result byte count above sixteen");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (({out_tdata[63:0], out_tdata[127:64]} &
                     ~byte_mask(out_tdata[132:128])) == '0))
    else $error("result bytes past the count are not zero");

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

endmodule
